### rtl/app_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the alpha point plotter
// no dependencies

package app_pkg;

  localparam int IMAGE_SIDE = 256;
  localparam int IDX_W      = $clog2(IMAGE_SIDE);
  localparam int PIX_COUNT  = IMAGE_SIDE * IMAGE_SIDE;
  localparam int ADDR_W     = $clog2(PIX_COUNT);
  localparam int PIXEL_W    = 24;
  localparam int PALETTE_SIZE = 10;

  localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 24'hFFFFFF;
  localparam logic [8:0]         ALPHA_FULL  = 9'd256;

  typedef enum logic [1:0] {
    ACT_PLOT   = 2'd0,
    ACT_READ   = 2'd1,
    ACT_WHITEN = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CFG_X_ORIGIN = 3'd0,
    CFG_Y_ORIGIN = 3'd1,
    CFG_X_SCALE  = 3'd2,
    CFG_Y_SCALE  = 3'd3,
    CFG_ALPHA    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        group_number;
    logic [7:0]         pixel_col;
    logic [7:0]         pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // step enables from the sequencer to the coordinate mapper
  typedef struct packed {
    logic diff_en;
    logic mul_en;
  } map_ctl_t;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [31:0] v);
    logic [IDX_W-1:0] res;
    if (v > 32'(IMAGE_SIDE - 1)) res = IDX_W'(IMAGE_SIDE - 1);
    else res = v[IDX_W-1:0];
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(col);
  endfunction

  function automatic pixel_t palette_color(input logic [3:0] sel);
    pixel_t c;
    case (sel)
      4'd0:    c = '{red: 8'd240, green: 8'd188, blue: 8'd0};
      4'd1:    c = '{red: 8'd178, green: 8'd57,  blue: 8'd147};
      4'd2:    c = '{red: 8'd39,  green: 8'd204, blue: 8'd122};
      4'd3:    c = '{red: 8'd21,  green: 8'd163, blue: 8'd206};
      4'd4:    c = '{red: 8'd235, green: 8'd84,  blue: 8'd54};
      4'd5:    c = '{red: 8'd138, green: 8'd103, blue: 8'd52};
      4'd6:    c = '{red: 8'd255, green: 8'd116, blue: 8'd116};
      4'd7:    c = '{red: 8'd120, green: 8'd80,  blue: 8'd171};
      4'd8:    c = '{red: 8'd48,  green: 8'd179, blue: 8'd179};
      4'd9:    c = '{red: 8'd211, green: 8'd47,  blue: 8'd91};
      default: c = '{red: 8'd240, green: 8'd188, blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

### rtl/alpha_point_plotter.sv
`timescale 1ns / 1ps
// plot, read and whiten sequencer around the pixel memory
// depends on app_pkg, app_ram, app_map, app_blend
//
// plot item: subtract, multiply, address and read, then blend and write back
//   through the registered memory read, before the next item is accepted
// read item: address and read, then the data step registers the result;
//   a read waits in the data step while an earlier result is held by out_stall
// whiten item: written white in the address step; an unused action code is dropped in idle
// reset: config to defaults, then the whole store (PIX_COUNT, 65536 pixels) is
//   whitened with in_stall high; config writes are taken throughout

module alpha_point_plotter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  app_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output app_pkg::pixel_t     out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import app_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIFF  = 6'b000100,
    S_MUL   = 6'b001000,
    S_ADDR  = 6'b010000,
    S_DATA  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  in_item_t          item_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  pixel_t            out_data_r, out_data_nxt;

  logic [31:0] x_origin_r, y_origin_r, x_scale_r, y_scale_r;
  logic [8:0]  alpha_r, alpha_sat;

  logic              in_accept;
  map_ctl_t          map_ctl;
  logic [IDX_W-1:0]  px, py;
  logic [3:0]        sel;
  logic [ADDR_W-1:0] addr_sel;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PIXEL_W-1:0] ram_wdata, ram_rdata;
  pixel_t            blend_pix;
  logic              slot_free;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= 32'd0;
      y_origin_r <= 32'd0;
      x_scale_r  <= 32'd65536;
      y_scale_r  <= 32'd65536;
      alpha_r    <= 9'd128;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_ORIGIN: x_origin_r <= cfg_data;
        CFG_Y_ORIGIN: y_origin_r <= cfg_data;
        CFG_X_SCALE:  x_scale_r  <= cfg_data;
        CFG_Y_SCALE:  y_scale_r  <= cfg_data;
        CFG_ALPHA:    alpha_r    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign alpha_sat = (alpha_r > ALPHA_FULL) ? ALPHA_FULL : alpha_r;

  app_map u_map (
    .clk          (clk),
    .ctl          (map_ctl),
    .point_x      (item_r.point_x),
    .point_y      (item_r.point_y),
    .group_number (item_r.group_number),
    .x_origin     (x_origin_r),
    .y_origin     (y_origin_r),
    .x_scale      (x_scale_r),
    .y_scale      (y_scale_r),
    .px           (px),
    .py           (py),
    .sel          (sel)
  );

  app_blend u_blend (
    .old_pix (pixel_t'(ram_rdata)),
    .color   (palette_color(sel)),
    .alpha   (alpha_sat),
    .new_pix (blend_pix)
  );

  app_ram #(
    .DEPTH (PIX_COUNT),
    .WIDTH (PIXEL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign addr_sel = (item_r.action == ACT_PLOT) ? pixel_addr(py, px) :
                    pixel_addr(clamp_idx(32'(item_r.pixel_row)),
                               clamp_idx(32'(item_r.pixel_col)));

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    addr_nxt      = addr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    map_ctl       = '{diff_en: 1'b0, mul_en: 1'b0};
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = WHITE_PIXEL;
    ram_re        = 1'b0;
    ram_raddr     = addr_sel;
    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(PIX_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          case (in_data.action)
            ACT_PLOT:   state_nxt = S_DIFF;
            ACT_READ:   state_nxt = S_ADDR;
            ACT_WHITEN: state_nxt = S_ADDR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIFF: begin
        map_ctl.diff_en = 1'b1;
        state_nxt       = S_MUL;
      end
      S_MUL: begin
        map_ctl.mul_en = 1'b1;
        state_nxt      = S_ADDR;
      end
      S_ADDR: begin
        addr_nxt = addr_sel;
        if (item_r.action == ACT_WHITEN) begin
          ram_we    = 1'b1;
          ram_waddr = addr_sel;
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (item_r.action == ACT_PLOT) begin
          ram_we    = 1'b1;
          ram_wdata = blend_pix;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pixel_t'(ram_rdata);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) item_r <= in_data;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // a new result only follows a read that reached the data state
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DATA) && $past(item_r.action == ACT_READ))
    else $error("result without a read");

  // the store is never written while the sequencer waits for an item
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r != S_IDLE)
    else $error("memory write in idle");

  // read and write never hit the memory in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("memory read and write overlap");

  // an accepted plot beat goes through the subtract step
  a_plot_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.action == ACT_PLOT |=> state_r == S_DIFF)
    else $error("plot beat skipped subtract step");

  // a plot write-back goes to the address latched at the read
  a_writeback_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DATA && item_r.action == ACT_PLOT |-> ram_waddr == $past(ram_raddr))
    else $error("write-back address differs from read address");
`endif

endmodule

### rtl/app_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module app_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/app_map.sv
`timescale 1ns / 1ps
// maps a q16.16 point to pixel coordinates and picks the palette entry
// depends on app_pkg

module app_map (
  input  logic                      clk,
  input  app_pkg::map_ctl_t         ctl,
  input  logic signed [31:0]        point_x,
  input  logic signed [31:0]        point_y,
  input  logic [31:0]               group_number,
  input  logic [31:0]               x_origin,
  input  logic [31:0]               y_origin,
  input  logic [31:0]               x_scale,
  input  logic [31:0]               y_scale,
  output logic [app_pkg::IDX_W-1:0] px,
  output logic [app_pkg::IDX_W-1:0] py,
  output logic [3:0]                sel
);
  import app_pkg::*;

  logic [32:0] dx_full, dy_full;
  logic [31:0] dx_r, dy_r;
  logic [63:0] prod_x, prod_y;
  logic [31:0] ipx_r, ipy_r;
  logic [6:0]  nib_sum, nib_sum_r;
  logic        odd_r;
  logic [2:0]  m5;
  logic [3:0]  sel_r;

  function automatic logic [2:0] mod5(input logic [6:0] v);
    logic [6:0] t;
    t = v;
    if (t >= 7'd80) t = t - 7'd80;
    if (t >= 7'd40) t = t - 7'd40;
    if (t >= 7'd20) t = t - 7'd20;
    if (t >= 7'd10) t = t - 7'd10;
    if (t >= 7'd5)  t = t - 7'd5;
    return t[2:0];
  endfunction

  // signed difference, negatives clamp to zero
  assign dx_full = {point_x[31], point_x} - {x_origin[31], x_origin};
  assign dy_full = {point_y[31], point_y} - {y_origin[31], y_origin};

  // 16 is 1 mod 5, so the nibble sum keeps the value mod 5
  always_comb begin
    nib_sum = '0;
    for (int i = 0; i < 8; i++) begin
      nib_sum = nib_sum + 7'(group_number[4*i +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      dx_r      <= dx_full[32] ? 32'd0 : dx_full[31:0];
      dy_r      <= dy_full[32] ? 32'd0 : dy_full[31:0];
      nib_sum_r <= nib_sum;
      odd_r     <= group_number[0];
    end
  end

  assign prod_x = {32'd0, dx_r} * {32'd0, x_scale};
  assign prod_y = {32'd0, dy_r} * {32'd0, y_scale};
  assign m5     = mod5(nib_sum_r);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      ipx_r <= prod_x[63:32];
      ipy_r <= prod_y[63:32];
      // combine mod 5 and parity into mod 10
      sel_r <= (m5[0] == odd_r) ? {1'b0, m5} : ({1'b0, m5} + 4'd5);
    end
  end

  assign px  = clamp_idx(ipx_r);
  assign py  = clamp_idx(ipy_r);
  assign sel = sel_r;

endmodule

### rtl/app_blend.sv
`timescale 1ns / 1ps
// per-channel alpha blend of a palette color into a stored pixel
// depends on app_pkg

module app_blend (
  input  app_pkg::pixel_t old_pix,
  input  app_pkg::pixel_t color,
  input  logic [8:0]      alpha,
  output app_pkg::pixel_t new_pix
);
  import app_pkg::*;

  function automatic logic [7:0] mix(input logic [7:0] old_c, input logic [7:0] new_c,
                                     input logic [8:0] a);
    logic [8:0]  inv;
    logic [16:0] p_old, p_new, acc;
    inv   = ALPHA_FULL - a;
    p_old = {8'd0, inv} * {9'd0, old_c};
    p_new = {8'd0, a} * {9'd0, new_c};
    acc   = p_old + p_new;
    return acc[15:8];
  endfunction

  assign new_pix.red   = mix(old_pix.red,   color.red,   alpha);
  assign new_pix.green = mix(old_pix.green, color.green, alpha);
  assign new_pix.blue  = mix(old_pix.blue,  color.blue,  alpha);

endmodule

### tb/alpha_point_plotter_test.sv
`timescale 1ns / 1ps
// self-checking bench for alpha_point_plotter: random plot, read and whiten beats
// over several register settings, checked against a shadow image in the bench
// depends on app_pkg and the alpha_point_plotter rtl

module alpha_point_plotter_test;
  import app_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int SQUEEZE_CYCLES = 400;
  localparam logic [23:0] SWATCH [0:9] = '{
    24'hF0BC00, 24'hB23993, 24'h27CC7A, 24'h15A3CE, 24'hEB5436,
    24'h8A6734, 24'hFF7474, 24'h7850AB, 24'h30B3B3, 24'hD32F5B
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pixel_t     out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  alpha_point_plotter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the image and the registers
  pixel_t             picture [PIX_COUNT];
  logic signed [31:0] org_x = '0;
  logic signed [31:0] org_y = '0;
  logic [31:0]        scl_x = 32'h0001_0000;
  logic [31:0]        scl_y = 32'h0001_0000;
  logic [8:0]         alpha_cfg = 9'd128;

  in_item_t    items_waiting [$];
  pixel_t      pixels_due [$];
  logic [15:0] recent_spots [$];

  int   errors = 0;
  int   plot_count = 0, read_count = 0, whiten_count = 0, ignored_count = 0;
  int   pixels_checked = 0;
  int   settings_used = 0;
  logic in_taken = 1'b0;
  int   gap_left = 0, stall_left = 0, hold_left = 0;
  int   hold_asked = 0, hold_given = 0;
  bit   send_gaps = 1'b0, recv_stalls = 1'b0;

  function automatic logic [IDX_W-1:0] axis_pixel(logic signed [31:0] pt,
                                                  logic signed [31:0] org,
                                                  logic [31:0] scl);
    longint     diff;
    logic [63:0] prod;
    diff = longint'(pt) - longint'(org);
    if (diff < 0) diff = 0;
    prod = 64'(diff) * 64'(scl);
    if (prod[63:32] > 64'(IMAGE_SIDE - 1)) return IDX_W'(IMAGE_SIDE - 1);
    return prod[32 +: IDX_W];
  endfunction

  function automatic logic [7:0] mix(logic [7:0] old, logic [7:0] col, int a);
    int v;
    v = ((256 - a) * int'(old) + a * int'(col)) >> 8;
    return 8'(v);
  endfunction

  // advance the shadow image by one accepted beat
  function automatic void apply_item(in_item_t it);
    logic [IDX_W-1:0] col, row;
    int     a;
    pixel_t old, paint, fresh;
    case (it.action)
      ACT_PLOT: begin
        col = axis_pixel(it.point_x, org_x, scl_x);
        row = axis_pixel(it.point_y, org_y, scl_y);
        a = (alpha_cfg > ALPHA_FULL) ? 256 : int'(alpha_cfg);
        old = picture[{row, col}];
        paint = SWATCH[it.group_number % 10];
        fresh.red = mix(old.red, paint.red, a);
        fresh.green = mix(old.green, paint.green, a);
        fresh.blue = mix(old.blue, paint.blue, a);
        picture[{row, col}] = fresh;
        plot_count++;
      end
      ACT_READ: begin
        pixels_due.push_back(picture[{it.pixel_row, it.pixel_col}]);
        read_count++;
      end
      ACT_WHITEN: begin
        picture[{it.pixel_row, it.pixel_col}] = WHITE_PIXEL;
        whiten_count++;
      end
      default: ignored_count++;
    endcase
  endfunction

  // input and output beats, sampled at the rising edge
  always @(posedge clk) begin : monitor
    pixel_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) apply_item(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        errors++;
        $error("pixel %h returned with no read outstanding", out_data);
      end else begin
        want = pixels_due.pop_front();
        pixels_checked++;
        if (out_data.red !== want.red) begin
          errors++;
          $error("red: expected %0d, got %0d", want.red, out_data.red);
        end
        if (out_data.green !== want.green) begin
          errors++;
          $error("green: expected %0d, got %0d", want.green, out_data.green);
        end
        if (out_data.blue !== want.blue) begin
          errors++;
          $error("blue: expected %0d, got %0d", want.blue, out_data.blue);
        end
      end
    end
  end

  // sender: next beat once the current one is taken, with random gap bursts
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (items_waiting.size() != 0) begin
        in_data <= items_waiting.pop_front();
        in_valid <= 1'b1;
        if (send_gaps && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      hold_given <= hold_asked;
      hold_left <= SQUEEZE_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t mk_plot(logic [31:0] x, logic [31:0] y, logic [31:0] grp);
    in_item_t it;
    it.action = ACT_PLOT;
    it.point_x = x;
    it.point_y = y;
    it.group_number = grp;
    it.pixel_col = 8'($urandom);
    it.pixel_row = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_pixel(action_t act, logic [7:0] col, logic [7:0] row);
    in_item_t it;
    it.action = act;
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.group_number = $urandom;
    it.pixel_col = col;
    it.pixel_row = row;
    return it;
  endfunction

  // half plots, mostly near the plotted area, reads and whitens often aimed at recent plots, some unused codes
  function automatic in_item_t random_item();
    in_item_t    it;
    int          pick;
    logic [15:0] spot;
    it = mk_pixel(ACT_PLOT, 8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if ($urandom_range(0, 3) != 0) begin
        it.point_x = org_x + 32'($urandom_range(0, 300 << 16)) - 32'(4 << 16);
        it.point_y = org_y + 32'($urandom_range(0, 300 << 16)) - 32'(4 << 16);
      end
      if ($urandom_range(0, 1) == 0) it.group_number = $urandom_range(0, 25);
      recent_spots.push_back({axis_pixel(it.point_y, org_y, scl_y),
                              axis_pixel(it.point_x, org_x, scl_x)});
      if (recent_spots.size() > 16) void'(recent_spots.pop_front());
    end else if (pick < 95) begin
      it.action = (pick < 85) ? ACT_READ : ACT_WHITEN;
      if (recent_spots.size() != 0 && $urandom_range(0, 9) < 6) begin
        spot = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
        it.pixel_col = spot[7:0];
        it.pixel_row = spot[15:8];
      end
    end else begin
      it.action = action_t'(2'b11);
    end
    return it;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_X_ORIGIN: org_x = val;
      CFG_Y_ORIGIN: org_y = val;
      CFG_X_SCALE:  scl_x = val;
      CFG_Y_SCALE:  scl_y = val;
      CFG_ALPHA:    alpha_cfg = val[8:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
                                 logic [31:0] ys, logic [8:0] al);
    write_reg(CFG_X_ORIGIN, xo);
    write_reg(CFG_Y_ORIGIN, yo);
    write_reg(CFG_X_SCALE, xs);
    write_reg(CFG_Y_SCALE, ys);
    write_reg(CFG_ALPHA, 32'(al));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // wait until every beat is taken and every read answered, then let the pipe empty
  task automatic settle();
    while (items_waiting.size() != 0 || in_valid || pixels_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int n, logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
                           logic [31:0] ys, logic [8:0] al, bit gaps, bit stalls,
                           bit squeeze);
    settle();
    program_setting(xo, yo, xs, ys, al);
    send_gaps = gaps;
    recv_stalls = stalls;
    if (squeeze) hold_asked++;
    repeat (n) items_waiting.push_back(random_item());
  endtask

  initial begin
    for (int i = 0; i < PIX_COUNT; i++) picture[i] = WHITE_PIXEL;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_setting(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd128);
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    // corners, origin clamp, saturation at the image edge, whiten, unused code
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd0, 8'd0));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd255, 8'd255));
    items_waiting.push_back(mk_plot(32'h0, 32'h0, 32'd0));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd0, 8'd0));
    items_waiting.push_back(mk_plot(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd0, 8'd0));
    items_waiting.push_back(mk_plot(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd9));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd255, 8'd255));
    items_waiting.push_back(mk_plot(32'h0003_8000, 32'h0007_4000, 32'd12));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd3, 8'd7));
    items_waiting.push_back(mk_pixel(ACT_WHITEN, 8'd0, 8'd0));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd0, 8'd0));
    items_waiting.push_back(mk_pixel(action_t'(2'b11), 8'd0, 8'd0));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd0, 8'd0));
    items_waiting.push_back(mk_pixel(ACT_WHITEN, 8'd255, 8'd255));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd255, 8'd255));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd0, 8'd255));
    // remaining palette entries stacked on one pixel
    for (int g = 1; g <= 8; g++)
      items_waiting.push_back(mk_plot(32'h0005_8000, 32'h0002_0000, 32'(g * 11)));
    items_waiting.push_back(mk_pixel(ACT_READ, 8'd5, 8'd2));

    run_phase(120, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd128, 1, 1, 0);
    run_phase(120, 32'hFFC0_0000, 32'h8000_0000, 32'h0004_0000, 32'h0000_8000, 9'd256,
              1, 0, 1);
    run_phase(120, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 9'd0, 0, 1, 0);
    run_phase(120, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'h0100_0000, 9'd511,
              1, 1, 0);
    run_phase(120, $urandom, $urandom, $urandom_range(32'h4000, 32'h40000),
              $urandom_range(32'h4000, 32'h40000), 9'd300, 1, 1, 0);
    // closing stretch runs back to back with no idling
    run_phase(120, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd200, 0, 0, 0);
    settle();

    $display("covered %0d plots, %0d reads, %0d whitens, %0d unused-code beats",
             plot_count, read_count, whiten_count, ignored_count);
    $display("%0d pixels compared across %0d register settings",
             pixels_checked, settings_used);
    if (errors == 0) begin
      $display("alpha_point_plotter_test: PASS");
    end else begin
      $display("alpha_point_plotter_test: FAIL");
    end
    $finish;
  end

  // watchdog well past the slowest legal run, clearing pass included
  initial begin
    #5_000_000;
    $display("alpha_point_plotter_test: FAIL");
    $finish;
  end

endmodule
